@@ sv/wsfp_pkg.sv @@
// shared types, constants and functions for the websocket frame header parser
package wsfp_pkg;

	// seven-bit length codes that call for an extended length
	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	// bytes in each part of the header
	localparam int unsigned BASE_BYTES  = 2;
	localparam int unsigned EXT16_BYTES = 2;
	localparam int unsigned EXT64_BYTES = 8;
	localparam int unsigned KEY_BYTES   = 4;

	// byte position counter
	localparam int unsigned POS_W   = 4;
	localparam int unsigned MAX_POS = BASE_BYTES + EXT64_BYTES + KEY_BYTES;

	// defined opcodes
	localparam logic [3:0] OP_CONT   = 4'h0;
	localparam logic [3:0] OP_TEXT   = 4'h1;
	localparam logic [3:0] OP_BINARY = 4'h2;
	localparam logic [3:0] OP_CLOSE  = 4'h8;
	localparam logic [3:0] OP_PING   = 4'h9;
	localparam logic [3:0] OP_PONG   = 4'hA;

	// form of the payload length field
	typedef enum logic [1:0] {
		FORM_SHORT = 2'd0,
		FORM_EXT16 = 2'd1,
		FORM_EXT64 = 2'd2
	} form_t;

	// one parsed header
	typedef struct packed {
		logic        final_frame;
		logic [2:0]  reserved_bits;
		logic [3:0]  frame_opcode;
		logic        is_masked;
		logic [63:0] payload_size;
		logic [31:0] mask_key;
		logic        header_ok;
	} hdr_t;

	// true for an opcode that the protocol defines
	function automatic logic opcode_defined(input logic [3:0] op);
		logic ok;
		case (op) inside
			OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG: ok = 1'b1;
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	// count of extended length bytes for a length form
	function automatic logic [POS_W-1:0] ext_bytes(input form_t form);
		logic [POS_W-1:0] n;
		unique case (form)
			FORM_EXT16: n = POS_W'(EXT16_BYTES);
			FORM_EXT64: n = POS_W'(EXT64_BYTES);
			default:    n = '0;
		endcase
		return n;
	endfunction

endpackage

@@ sv/wsfp_byte_if.sv @@
// byte stream channel into the header parser
interface wsfp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic       starts_header;

	modport source (output valid, output header_byte, output starts_header, input ready);
	modport sink (input valid, input header_byte, input starts_header, output ready);
endinterface

@@ sv/wsfp_hdr_if.sv @@
// parsed header channel out of the header parser
interface wsfp_hdr_if;
	logic        valid;
	logic        ready;
	logic        final_frame;
	logic [2:0]  reserved_bits;
	logic [3:0]  frame_opcode;
	logic        is_masked;
	logic [63:0] payload_size;
	logic [31:0] mask_key;
	logic        header_ok;

	modport source (
		output valid, output final_frame, output reserved_bits, output frame_opcode,
		output is_masked, output payload_size, output mask_key, output header_ok,
		input ready
	);
	modport sink (
		input valid, input final_frame, input reserved_bits, input frame_opcode,
		input is_masked, input payload_size, input mask_key, input header_ok,
		output ready
	);
endinterface

@@ sv/wsfp_parser.sv @@
// header parse state and per-byte step logic
module wsfp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          header_byte,
	input  logic                starts_header,
	output logic                emit,
	output wsfp_pkg::hdr_t      hdr
);

	logic [wsfp_pkg::POS_W-1:0] pos_q;
	wsfp_pkg::form_t            form_q;
	logic [7:0]                 first_q;
	logic                       mask_q;
	logic [63:0]                len_q;
	logic [31:0]                key_q;

	logic [wsfp_pkg::POS_W-1:0] len_end;
	logic [wsfp_pkg::POS_W-1:0] hdr_end;
	logic [wsfp_pkg::POS_W-1:0] pos_next;
	logic [6:0]                 len7;
	logic                       in_len;
	logic                       past_end;
	logic                       last_key;

	// header layout for the current length form
	assign len_end  = wsfp_pkg::POS_W'(wsfp_pkg::BASE_BYTES) + wsfp_pkg::ext_bytes(form_q);
	assign hdr_end  = len_end + wsfp_pkg::POS_W'(wsfp_pkg::KEY_BYTES);
	assign pos_next = pos_q + 1'b1;
	assign len7     = header_byte[6:0];
	assign past_end = pos_q >= hdr_end;
	assign in_len   = pos_q < len_end;
	assign last_key = !(pos_next < hdr_end);

	// a header completes on its last key byte
	assign emit = step && !starts_header && (pos_q > wsfp_pkg::POS_W'(1))
		&& !past_end && !in_len && last_key;

	// result fields, key includes the byte now arriving
	always_comb begin
		hdr.final_frame   = first_q[7];
		hdr.reserved_bits = first_q[6:4];
		hdr.frame_opcode  = first_q[3:0];
		hdr.is_masked     = mask_q;
		hdr.payload_size  = len_q;
		hdr.mask_key      = {key_q[23:0], header_byte};
		hdr.header_ok     = (first_q[6:4] == 3'd0) && wsfp_pkg::opcode_defined(first_q[3:0])
			&& mask_q;
	end

	// parse state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			form_q  <= wsfp_pkg::FORM_SHORT;
			first_q <= '0;
			mask_q  <= 1'b0;
			len_q   <= '0;
			key_q   <= '0;
		end else if (step) begin
			if (starts_header) begin
				first_q <= header_byte;
				mask_q  <= 1'b0;
				form_q  <= wsfp_pkg::FORM_SHORT;
				len_q   <= '0;
				key_q   <= '0;
				pos_q   <= wsfp_pkg::POS_W'(1);
			end else if (pos_q == '0) begin
				// idle, byte dropped
			end else if (pos_q == wsfp_pkg::POS_W'(1)) begin
				mask_q <= header_byte[7];
				if (len7 == wsfp_pkg::LEN_EXT16) begin
					form_q <= wsfp_pkg::FORM_EXT16;
					len_q  <= '0;
				end else if (len7 == wsfp_pkg::LEN_EXT64) begin
					form_q <= wsfp_pkg::FORM_EXT64;
					len_q  <= '0;
				end else begin
					form_q <= wsfp_pkg::FORM_SHORT;
					len_q  <= 64'(len7);
				end
				pos_q <= wsfp_pkg::POS_W'(2);
			end else if (past_end) begin
				pos_q <= '0;
			end else if (in_len) begin
				len_q <= {len_q[55:0], header_byte};
				pos_q <= pos_next;
			end else begin
				key_q <= {key_q[23:0], header_byte};
				pos_q <= last_key ? '0 : pos_next;
			end
		end
	end

	// position never runs past the longest header
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= wsfp_pkg::POS_W'(wsfp_pkg::MAX_POS))
		else $error("byte position beyond longest header");

	// a first byte always restarts at position one
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		step && starts_header |=> pos_q == wsfp_pkg::POS_W'(1))
		else $error("restart did not set position one");

	// a completed header returns the parser to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> pos_q == '0)
		else $error("parser not idle after completed header");

	// a completed header only comes from a running parse
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> pos_q >= wsfp_pkg::POS_W'(wsfp_pkg::BASE_BYTES + wsfp_pkg::KEY_BYTES - 1))
		else $error("header completed too early");

endmodule

@@ sv/websocket_frame_header_parser.sv @@
// Frame header parser for the websocket protocol. Header bytes enter on the byte channel, one
// transaction per byte, with starts_header marking the first byte of each header; that flag
// always drops any partial header. After the two base bytes come two or eight big-endian
// extended length bytes when the seven-bit length is 126 or 127, and then four masking key
// bytes whether or not MASK is set. The last key byte yields one transaction on the header
// channel carrying all fields and header_ok. A byte is accepted every cycle while results are
// taken; each byte passes through one input register, a single step of the position counter
// and one result register.
module websocket_frame_header_parser (
	input  logic       clk,
	input  logic       arst_n,
	wsfp_byte_if.sink  hdr_bytes,
	wsfp_hdr_if.source hdr_result
);

	logic           valid_s1;
	logic [7:0]     byte_s1;
	logic           start_s1;
	logic           res_valid_q;
	wsfp_pkg::hdr_t res_q;
	logic           advance;
	logic           step;
	logic           emit;
	wsfp_pkg::hdr_t hdr;

	// input stage moves on whenever the result register can take a transaction
	assign advance         = !res_valid_q || hdr_result.ready;
	assign step            = valid_s1 && advance;
	assign hdr_bytes.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (hdr_bytes.valid && hdr_bytes.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_bytes.valid && hdr_bytes.ready) begin
			byte_s1  <= hdr_bytes.header_byte;
			start_s1 <= hdr_bytes.starts_header;
		end
	end

	// parse state and step
	wsfp_parser u_parser (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.header_byte   (byte_s1),
		.starts_header (start_s1),
		.emit          (emit),
		.hdr           (hdr)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= hdr;
		end
	end

	// output channel
	assign hdr_result.valid         = res_valid_q;
	assign hdr_result.final_frame   = res_q.final_frame;
	assign hdr_result.reserved_bits = res_q.reserved_bits;
	assign hdr_result.frame_opcode  = res_q.frame_opcode;
	assign hdr_result.is_masked     = res_q.is_masked;
	assign hdr_result.payload_size  = res_q.payload_size;
	assign hdr_result.mask_key      = res_q.mask_key;
	assign hdr_result.header_ok     = res_q.header_ok;

endmodule
